// File: rtl/core/dipm_pkg.sv
`timescale 1ns / 1ps

package dipm_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 18;
  localparam int DtW     = 5;
  localparam int OpW     = 20;
  localparam int ProdW   = OpW + CoefW;
  localparam int AccW    = 56;
  localparam int LoW     = 19;
  localparam int HiMsb   = 37;
  localparam int RndBit  = 27;
  localparam int QShift  = 28;
  localparam int PcW     = 4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [2:0] REG_B0    = 3'd0;
  localparam logic [2:0] REG_B1    = 3'd1;
  localparam logic [2:0] REG_B2    = 3'd2;
  localparam logic [2:0] REG_A1    = 3'd3;
  localparam logic [2:0] REG_A2    = 3'd4;
  localparam logic [2:0] REG_RECIP = 3'd5;
  localparam logic [2:0] REG_DT    = 3'd6;

  typedef enum logic [2:0] {
    ASEL_ZERO,
    ASEL_HIST,
    ASEL_Y0,
    ASEL_Y1,
    ASEL_LO,
    ASEL_HI
  } asel_e;

  typedef enum logic [2:0] {
    BSEL_B0,
    BSEL_B1,
    BSEL_B2,
    BSEL_A1,
    BSEL_A2,
    BSEL_RECIP
  } bsel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ADD_HI
  } accop_e;

  typedef enum logic [1:0] {
    NXT_STEP,
    NXT_WAIT,
    NXT_END
  } next_e;

  typedef struct packed {
    logic       rd_en;
    logic [1:0] tap;
    asel_e      asel;
    bsel_e      bsel;
    accop_e     acc_op;
    next_e      nxt;
    logic       finish;
  } ctrl_t;

  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
    logic signed [CoefW-1:0] recip;
    logic [DtW-1:0]          dead_time;
  } coef_t;

  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    w.rd_en  = 1'b0;
    w.tap    = 2'd0;
    w.asel   = ASEL_ZERO;
    w.bsel   = BSEL_B0;
    w.acc_op = ACC_HOLD;
    w.nxt    = NXT_STEP;
    w.finish = 1'b0;
    case (pc)
      4'd0: begin
        w.nxt = NXT_WAIT;
      end
      4'd1: begin
        w.rd_en = 1'b1;
        w.tap   = 2'd0;
      end
      4'd2: begin
        w.rd_en = 1'b1;
        w.tap   = 2'd1;
        w.asel  = ASEL_HIST;
        w.bsel  = BSEL_B0;
      end
      4'd3: begin
        w.rd_en  = 1'b1;
        w.tap    = 2'd2;
        w.asel   = ASEL_HIST;
        w.bsel   = BSEL_B1;
        w.acc_op = ACC_LOAD;
      end
      4'd4: begin
        w.asel   = ASEL_HIST;
        w.bsel   = BSEL_B2;
        w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.asel   = ASEL_Y0;
        w.bsel   = BSEL_A1;
        w.acc_op = ACC_ADD;
      end
      4'd6: begin
        w.asel   = ASEL_Y1;
        w.bsel   = BSEL_A2;
        w.acc_op = ACC_SUB;
      end
      4'd7: begin
        w.acc_op = ACC_SUB;
      end
      4'd8: begin
        w.asel = ASEL_LO;
        w.bsel = BSEL_RECIP;
      end
      4'd9: begin
        w.asel   = ASEL_HI;
        w.bsel   = BSEL_RECIP;
        w.acc_op = ACC_LOAD;
      end
      4'd10: begin
        w.acc_op = ACC_ADD_HI;
      end
      4'd11: begin
        w.finish = 1'b1;
        w.nxt    = NXT_END;
      end
      default: begin
        w.nxt = NXT_END;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/dipm_sequencer.sv
`timescale 1ns / 1ps

module dipm_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            stall_i,
  output dipm_pkg::ctrl_t ctrl_o,
  output logic            commit_o,
  output logic            idle_o
);

  logic [dipm_pkg::PcW-1:0] pc_q, pc_d;
  dipm_pkg::ctrl_t          ctrl;

  assign ctrl     = dipm_pkg::ucode(pc_q);
  assign ctrl_o   = ctrl;
  assign idle_o   = (ctrl.nxt == dipm_pkg::NXT_WAIT);
  assign commit_o = ctrl.finish && !stall_i;

  always_comb begin
    pc_d = pc_q;
    case (ctrl.nxt)
      dipm_pkg::NXT_WAIT: begin
        if (start_i) pc_d = pc_q + 1'b1;
      end
      dipm_pkg::NXT_STEP: begin
        pc_d = pc_q + 1'b1;
      end
      dipm_pkg::NXT_END: begin
        if (!stall_i) pc_d = '0;
      end
      default: begin
        pc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: rtl/core/dipm_datapath.sv
`timescale 1ns / 1ps

module dipm_datapath #(
  parameter int MAX_DEAD_TIME = 16,
  parameter int NUM_TAPS      = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dipm_pkg::ctrl_t                       ctrl_i,
  input  dipm_pkg::coef_t                       coef_i,
  input  logic                                  push_i,
  input  logic                                  clear_i,
  input  logic                                  commit_i,
  input  logic signed [dipm_pkg::SampleW-1:0]   sample_i,
  output logic signed [dipm_pkg::SampleW-1:0]   y_o
);

  localparam int Depth = MAX_DEAD_TIME + NUM_TAPS - 1;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int IW    = AW + 1;

  logic signed [dipm_pkg::SampleW-1:0] mem_q [Depth];
  logic signed [dipm_pkg::SampleW-1:0] rdata_q;
  logic                                rvalid_q;
  logic [Depth-1:0]                    hv_q;
  logic [AW-1:0]                       wp_q, wp_d;

  logic [7:0]    dt8, dcl8;
  logic [IW-1:0] idx, wpx, raddr_x;
  logic [AW-1:0] raddr;
  logic          tap_used;

  logic signed [dipm_pkg::SampleW-1:0] y0_q, y1_q;
  logic signed [dipm_pkg::OpW-1:0]     a_op;
  logic signed [dipm_pkg::CoefW-1:0]   b_op;
  logic signed [dipm_pkg::ProdW-1:0]   prod_d, prod_q;
  logic signed [dipm_pkg::AccW-1:0]    acc_q, acc_d, rnd;
  logic signed [dipm_pkg::AccW-dipm_pkg::QShift-1:0] q;

  assign wp_d = (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;

  assign dt8  = 8'(coef_i.dead_time);
  assign dcl8 = (dt8 == 8'd0) ? 8'd1 :
                (dt8 > 8'(MAX_DEAD_TIME)) ? 8'(MAX_DEAD_TIME) : dt8;
  assign idx      = IW'(dcl8) - IW'(1) + IW'(ctrl_i.tap);
  assign wpx      = {1'b0, wp_q};
  assign raddr_x  = (wpx >= idx) ? wpx - idx : wpx + IW'(Depth) - idx;
  assign raddr    = raddr_x[AW-1:0];
  assign tap_used = int'(ctrl_i.tap) < NUM_TAPS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      hv_q <= '0;
    end else if (clear_i) begin
      hv_q <= '0;
    end else if (push_i) begin
      wp_q       <= wp_d;
      hv_q[wp_d] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_d] <= sample_i;
    if (ctrl_i.rd_en) begin
      rdata_q  <= mem_q[raddr];
      rvalid_q <= hv_q[raddr] && tap_used;
    end
  end

  always_comb begin
    case (ctrl_i.asel)
      dipm_pkg::ASEL_HIST: a_op = rvalid_q ? dipm_pkg::OpW'(rdata_q) : '0;
      dipm_pkg::ASEL_Y0:   a_op = dipm_pkg::OpW'(y0_q);
      dipm_pkg::ASEL_Y1:   a_op = dipm_pkg::OpW'(y1_q);
      dipm_pkg::ASEL_LO:   a_op = {1'b0, acc_q[dipm_pkg::LoW-1:0]};
      dipm_pkg::ASEL_HI:
        a_op = dipm_pkg::OpW'($signed(acc_q[dipm_pkg::HiMsb:dipm_pkg::LoW]));
      default:             a_op = '0;
    endcase
    case (ctrl_i.bsel)
      dipm_pkg::BSEL_B0:    b_op = coef_i.b0;
      dipm_pkg::BSEL_B1:    b_op = coef_i.b1;
      dipm_pkg::BSEL_B2:    b_op = coef_i.b2;
      dipm_pkg::BSEL_A1:    b_op = coef_i.a1;
      dipm_pkg::BSEL_A2:    b_op = coef_i.a2;
      dipm_pkg::BSEL_RECIP: b_op = coef_i.recip;
      default:              b_op = '0;
    endcase
  end

  assign prod_d = a_op * b_op;

  always_comb begin
    case (ctrl_i.acc_op)
      dipm_pkg::ACC_LOAD: acc_d = dipm_pkg::AccW'(prod_q);
      dipm_pkg::ACC_ADD:  acc_d = acc_q + dipm_pkg::AccW'(prod_q);
      dipm_pkg::ACC_SUB:  acc_d = acc_q - dipm_pkg::AccW'(prod_q);
      dipm_pkg::ACC_ADD_HI:
        acc_d = acc_q + (dipm_pkg::AccW'(prod_q) <<< dipm_pkg::LoW);
      default:            acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // round half up at 2^-28, then saturate to 16 bits
  assign rnd = acc_q + (dipm_pkg::AccW'(1) <<< dipm_pkg::RndBit);
  assign q   = rnd[dipm_pkg::AccW-1:dipm_pkg::QShift];

  always_comb begin
    if (q > 28'sd32767) begin
      y_o = 16'sh7fff;
    end else if (q < -28'sd32768) begin
      y_o = -16'sh8000;
    end else begin
      y_o = q[dipm_pkg::SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y0_q <= '0;
      y1_q <= '0;
    end else if (clear_i) begin
      y0_q <= '0;
      y1_q <= '0;
    end else if (commit_i) begin
      y0_q <= y_o;
      y1_q <= y0_q;
    end
  end

endmodule

// File: rtl/core/delayed_iir_plant_model_core.sv
`timescale 1ns / 1ps

// Second-order direct-form I plant model with an input dead time of 1 to
// MAX_DEAD_TIME samples. A sample transfer (opcode 0) yields one saturated
// plant_output; a clear transfer (opcode 1) zeroes both histories and yields
// nothing. A new sample is accepted only after the previous one has finished
// a 12-step microprogram, which runs every product (three input taps, two
// feedback taps, then the reciprocal of a0 in two halves) through one shared
// 20x18 multiplier and accumulator. in_ready_o is high only between samples;
// the result sits in an output register, so the next sample starts while it
// waits, and only the final step holds if that register is still full.
// Coefficient and dead-time registers sit on the APB port at byte offsets
// 0x00 to 0x18 and are to be written only while the block is idle; the block
// itself does not enforce this.
module delayed_iir_plant_model_core #(
  parameter int MAX_DEAD_TIME = 16,
  parameter int NUM_TAPS      = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [15:0] drive_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] plant_output_o
);

  dipm_pkg::coef_t coef_q;
  dipm_pkg::ctrl_t ctrl;
  logic [2:0]      reg_idx;
  logic            wr_en, accept, start, clear, idle, commit;
  logic            out_valid_q;
  logic signed [15:0] out_q, y;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0        <= '0;
      coef_q.b1        <= '0;
      coef_q.b2        <= '0;
      coef_q.a1        <= '0;
      coef_q.a2        <= '0;
      coef_q.recip     <= 18'sd16384;
      coef_q.dead_time <= 5'd1;
    end else if (wr_en) begin
      case (reg_idx)
        dipm_pkg::REG_B0:    coef_q.b0        <= pwdata[17:0];
        dipm_pkg::REG_B1:    coef_q.b1        <= pwdata[17:0];
        dipm_pkg::REG_B2:    coef_q.b2        <= pwdata[17:0];
        dipm_pkg::REG_A1:    coef_q.a1        <= pwdata[17:0];
        dipm_pkg::REG_A2:    coef_q.a2        <= pwdata[17:0];
        dipm_pkg::REG_RECIP: coef_q.recip     <= pwdata[17:0];
        dipm_pkg::REG_DT:    coef_q.dead_time <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dipm_pkg::REG_B0:    prdata = {14'd0, coef_q.b0};
      dipm_pkg::REG_B1:    prdata = {14'd0, coef_q.b1};
      dipm_pkg::REG_B2:    prdata = {14'd0, coef_q.b2};
      dipm_pkg::REG_A1:    prdata = {14'd0, coef_q.a1};
      dipm_pkg::REG_A2:    prdata = {14'd0, coef_q.a2};
      dipm_pkg::REG_RECIP: prdata = {14'd0, coef_q.recip};
      dipm_pkg::REG_DT:    prdata = {27'd0, coef_q.dead_time};
      default:             prdata = '0;
    endcase
  end

  assign in_ready_o = idle;
  assign accept     = in_valid_i && idle;
  assign start      = accept && (opcode_i == dipm_pkg::OP_SAMPLE);
  assign clear      = accept && (opcode_i == dipm_pkg::OP_CLEAR);

  dipm_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .stall_i  (out_valid_q && !out_ready_i),
    .ctrl_o   (ctrl),
    .commit_o (commit),
    .idle_o   (idle)
  );

  dipm_datapath #(
    .MAX_DEAD_TIME (MAX_DEAD_TIME),
    .NUM_TAPS      (NUM_TAPS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .coef_i   (coef_q),
    .push_i   (start),
    .clear_i  (clear),
    .commit_i (commit),
    .sample_i (drive_sample_i),
    .y_o      (y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) out_q <= y;
  end

  assign out_valid_o    = out_valid_q;
  assign plant_output_o = out_q;

endmodule
